FILE: hdl/lcre_pkg.sv
// Shared types, constants and character classes for the run expander.
`timescale 1ns / 1ps
`default_nettype none

package lcre_pkg;

    // Widths of the character and run count paths.
    localparam int CHAR_W = 8;
    localparam int LETTER_W = 7;
    localparam int CNT_W = 6;
    localparam int DIGIT_W = 4;
    localparam int PROD_W = CNT_W + DIGIT_W;

    // Default saturation limit of a run count.
    localparam int MAX_RUN_DEF = 63;

    // Character codes used by the classifier and the digit path.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7A;

    // Operations of the shared count unit.
    localparam int OP_W = 1;
    localparam logic [OP_W-1:0] OP_DEC = 1'b0;
    localparam logic [OP_W-1:0] OP_MAC = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_of_item;
        logic              pattern_done;
    } t_out_item;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
               ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/letter_count_run_expander.sv
// Top level of the letter and decimal count run expander.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  input   | in        | i_in_valid / o_in_stall    | i_char_in, i_string_end
//  output  | out       | o_out_valid / i_out_stall  | o_char_out, o_last_of_item,
//          |           |                            | o_pattern_done
//
// A request is taken only while the sequencer is idle; a digit that extends a held
// run passes through the shared count unit. The sequencer then loads the results of
// the request one by one into the output register: a digit flushes at most MAX_RUN
// results, any other request at most MAX_RUN + 1.
// Reset is synchronous and active low and leaves no letter held; no clearing pass.
// While the output is stalled with a result held, the sequencer waits with its next result pending.
`timescale 1ns / 1ps
`default_nettype none

module letter_count_run_expander #(
    parameter int MAX_RUN = lcre_pkg::MAX_RUN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [lcre_pkg::CHAR_W-1:0] i_char_in,
    input  wire logic                        i_string_end,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [lcre_pkg::CHAR_W-1:0] o_char_out,
    output logic                             o_last_of_item,
    output logic                             o_pattern_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_TAIL = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic                          r_held_valid, n_held_valid;
    logic [lcre_pkg::LETTER_W-1:0] r_held_letter, n_held_letter;
    logic [lcre_pkg::CNT_W-1:0]    r_run_count, n_run_count;
    logic                          r_count_seen, n_count_seen;
    logic [lcre_pkg::CNT_W-1:0]    r_rem, n_rem;
    logic                          r_tail, n_tail;
    logic                          r_end, n_end;
    logic [lcre_pkg::CHAR_W-1:0]   r_char, n_char;
    logic [lcre_pkg::LETTER_W-1:0] r_run_char, n_run_char;

    logic                          w_in_acc;
    logic                          w_is_letter;
    logic                          w_is_digit;
    logic [lcre_pkg::CNT_W-1:0]    w_reps;
    logic [lcre_pkg::CHAR_W-1:0]   w_diff;
    logic [lcre_pkg::OP_W-1:0]     w_op;
    logic [lcre_pkg::CNT_W-1:0]    w_alu_a;
    logic [lcre_pkg::CNT_W-1:0]    w_alu_res;
    logic                          w_load;
    logic                          w_free;
    logic                          w_last;
    lcre_pkg::t_out_item           w_item;
    lcre_pkg::t_out_item           w_out_item;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_is_letter = lcre_pkg::is_letter(i_char_in);
    assign w_is_digit  = lcre_pkg::is_digit(i_char_in);

    // A held letter with no digits after it is emitted once.
    assign w_reps = !r_held_valid ? '0 :
                    (r_count_seen ? r_run_count : lcre_pkg::CNT_W'(1));

    assign w_diff  = r_char - lcre_pkg::CHAR_ZERO;
    assign w_op    = (r_state == S_MAC) ? lcre_pkg::OP_MAC : lcre_pkg::OP_DEC;
    assign w_alu_a = (r_state == S_MAC) ? r_run_count : r_rem;

    lcre_arith #(
        .MAX_RUN (MAX_RUN)
    ) u_arith (
        .i_op    (w_op),
        .i_a     (w_alu_a),
        .i_digit (w_diff[lcre_pkg::DIGIT_W-1:0]),
        .o_res   (w_alu_res)
    );

    assign w_last = (r_rem == lcre_pkg::CNT_W'(1)) && !r_tail;

    always_comb begin
        n_state       = r_state;
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        n_run_count   = r_run_count;
        n_count_seen  = r_count_seen;
        n_rem         = r_rem;
        n_tail        = r_tail;
        n_end         = r_end;
        n_char        = r_char;
        n_run_char    = r_run_char;
        w_load        = 1'b0;
        w_item        = '{char_out: {1'b0, r_run_char}, last_of_item: 1'b0,
                          pattern_done: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_char     = i_char_in;
                    n_end      = i_string_end;
                    n_run_char = r_held_letter;
                    if (w_is_digit) begin
                        // A digit with no letter held is dropped.
                        if (r_held_valid) begin
                            n_state = S_MAC;
                        end
                    end else begin
                        n_rem  = w_reps;
                        n_tail = w_is_letter ? i_string_end : 1'b1;
                        if (w_is_letter && !i_string_end) begin
                            n_held_valid  = 1'b1;
                            n_held_letter = i_char_in[lcre_pkg::LETTER_W-1:0];
                        end else begin
                            n_held_valid  = 1'b0;
                            n_held_letter = '0;
                        end
                        n_run_count  = '0;
                        n_count_seen = 1'b0;
                        if (w_reps != '0) begin
                            n_state = S_RUN;
                        end else if (n_tail) begin
                            n_state = S_TAIL;
                        end
                    end
                end
            end
            S_MAC: begin
                n_run_count  = w_alu_res;
                n_count_seen = 1'b1;
                n_state      = S_IDLE;
                if (r_end) begin
                    n_rem         = w_alu_res;
                    n_tail        = 1'b0;
                    n_run_char    = r_held_letter;
                    n_held_valid  = 1'b0;
                    n_held_letter = '0;
                    n_run_count   = '0;
                    n_count_seen  = 1'b0;
                    if (w_alu_res != '0) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (w_free) begin
                    w_load = 1'b1;
                    w_item = '{char_out: {1'b0, r_run_char}, last_of_item: w_last,
                               pattern_done: w_last && r_end};
                    n_rem  = w_alu_res;
                    if (r_rem == lcre_pkg::CNT_W'(1)) begin
                        n_state = r_tail ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    w_item  = '{char_out: r_char, last_of_item: 1'b1, pattern_done: r_end};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
            r_run_count   <= '0;
            r_count_seen  <= 1'b0;
            r_rem         <= '0;
            r_tail        <= 1'b0;
            r_end         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
            r_run_count   <= n_run_count;
            r_count_seen  <= n_count_seen;
            r_rem         <= n_rem;
            r_tail        <= n_tail;
            r_end         <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_run_char <= n_run_char;
    end

    lcre_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_item  (w_item),
        .i_stall (i_out_stall),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .o_item  (w_out_item)
    );

    assign o_char_out     = w_out_item.char_out;
    assign o_last_of_item = w_out_item.last_of_item;
    assign o_pattern_done = w_out_item.pattern_done;

`ifndef SYNTHESIS
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rem != '0))
        else $error("Run emission entered with no repetitions left.");

    a_seen_needs_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_seen |-> r_held_valid)
        else $error("Count marked as seen while no letter is held.");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pattern_done) |-> o_last_of_item)
        else $error("Pattern end flagged on a result that is not the last of its request.");

    a_letter_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_letter && !i_string_end) |=> (r_held_valid && !r_count_seen))
        else $error("Accepted letter was not held as a fresh run.");
`endif

endmodule

`default_nettype wire

FILE: hdl/lcre_arith.sv
// Shared count unit: decimal multiply-accumulate with saturation, or decrement.
`timescale 1ns / 1ps
`default_nettype none

module lcre_arith #(
    parameter int MAX_RUN = lcre_pkg::MAX_RUN_DEF
) (
    input  wire logic [lcre_pkg::OP_W-1:0]    i_op,
    input  wire logic [lcre_pkg::CNT_W-1:0]   i_a,
    input  wire logic [lcre_pkg::DIGIT_W-1:0] i_digit,
    output logic      [lcre_pkg::CNT_W-1:0]   o_res
);

    logic [lcre_pkg::PROD_W-1:0] w_a_ext;
    logic [lcre_pkg::PROD_W-1:0] w_sum;
    logic [lcre_pkg::CNT_W-1:0]  w_mac;
    logic [lcre_pkg::CNT_W-1:0]  w_dec;

    assign w_a_ext = lcre_pkg::PROD_W'(i_a);

    // Times ten is eight times plus two times.
    assign w_sum = (w_a_ext << 3) + (w_a_ext << 1) + lcre_pkg::PROD_W'(i_digit);

    assign w_mac = (w_sum > lcre_pkg::PROD_W'(MAX_RUN)) ? lcre_pkg::CNT_W'(MAX_RUN)
                                                         : w_sum[lcre_pkg::CNT_W-1:0];
    assign w_dec = i_a - lcre_pkg::CNT_W'(1);

    always_comb begin
        case (i_op)
            lcre_pkg::OP_MAC: o_res = w_mac;
            lcre_pkg::OP_DEC: o_res = w_dec;
            default:          o_res = w_dec;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lcre_out_reg.sv
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module lcre_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire lcre_pkg::t_out_item i_item,
    input  wire logic                i_stall,
    output logic                     o_free,
    output logic                     o_valid,
    output lcre_pkg::t_out_item      o_item
);

    logic                r_valid;
    logic                n_valid;
    lcre_pkg::t_out_item r_item;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: tb/letter_count_run_expander_test.sv
// Self-checking testbench for the letter and decimal count run expander.
`timescale 1ns / 1ps

module letter_count_run_expander_test;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RUN_LIMIT = lcre_pkg::MAX_RUN_DEF;
    localparam int DECIMAL_BASE = 10;
    // Longest stretch with no accepted request or result before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to wait after the last expected result.
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic [1:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_OTHER
    } t_char_class;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [lcre_pkg::CHAR_W-1:0] i_char_in = '0;
    logic                        i_string_end = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [lcre_pkg::CHAR_W-1:0] o_char_out;
    logic                        o_last_of_item;
    logic                        o_pattern_done;

    // Shadow of the run that the block is holding.
    logic                          run_held = 1'b0;
    logic [lcre_pkg::LETTER_W-1:0] run_letter = '0;
    logic [lcre_pkg::CNT_W-1:0]    run_len = '0;
    logic                          run_has_digits = 1'b0;

    lcre_pkg::t_out_item expected_chars[$];

    int fail_count = 0;
    int requests_sent = 0;
    int chars_checked = 0;
    int patterns_closed = 0;
    int longest_run = 0;

    bit idle_on = 1'b1;
    int stall_pct = 0;
    int stall_left = 0;

    letter_count_run_expander #(
        .MAX_RUN(RUN_LIMIT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_in     (i_char_in),
        .i_string_end  (i_string_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_char_out    (o_char_out),
        .o_last_of_item(o_last_of_item),
        .o_pattern_done(o_pattern_done)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_char_class classify(logic [lcre_pkg::CHAR_W-1:0] c);
        if (((c >= lcre_pkg::CHAR_UP_A) && (c <= lcre_pkg::CHAR_UP_Z)) ||
            ((c >= lcre_pkg::CHAR_LO_A) && (c <= lcre_pkg::CHAR_LO_Z))) begin
            return CLS_LETTER;
        end
        if ((c >= lcre_pkg::CHAR_ZERO) && (c <= lcre_pkg::CHAR_NINE)) begin
            return CLS_DIGIT;
        end
        return CLS_OTHER;
    endfunction

    function automatic void emit_expected(logic [lcre_pkg::CHAR_W-1:0] c);
        lcre_pkg::t_out_item item;
        item.char_out = c;
        item.last_of_item = 1'b0;
        item.pattern_done = 1'b0;
        expected_chars.push_back(item);
    endfunction

    function automatic void flush_held_run();
        int reps;
        if (run_held) begin
            reps = run_has_digits ? int'(run_len) : 1;
            if (reps > longest_run) begin
                longest_run = reps;
            end
            repeat (reps) emit_expected({1'b0, run_letter});
        end
        run_held = 1'b0;
        run_letter = '0;
        run_len = '0;
        run_has_digits = 1'b0;
    endfunction

    // Appends the characters that one accepted request produces.
    function automatic void predict_expansion(logic [lcre_pkg::CHAR_W-1:0] c,
                                              logic last_char);
        int before_n;
        int acc;
        lcre_pkg::t_out_item tail;
        before_n = expected_chars.size();
        case (classify(c))
            CLS_LETTER: begin
                flush_held_run();
                run_held = 1'b1;
                run_letter = c[lcre_pkg::LETTER_W-1:0];
                run_len = '0;
                run_has_digits = 1'b0;
            end
            CLS_DIGIT: begin
                // A digit with no letter held is dropped.
                if (run_held) begin
                    acc = int'(run_len) * DECIMAL_BASE + int'(c - lcre_pkg::CHAR_ZERO);
                    if (acc > RUN_LIMIT) begin
                        acc = RUN_LIMIT;
                    end
                    run_len = acc[lcre_pkg::CNT_W-1:0];
                    run_has_digits = 1'b1;
                end
            end
            default: begin
                flush_held_run();
                emit_expected(c);
            end
        endcase
        if (last_char) begin
            flush_held_run();
        end
        if (expected_chars.size() > before_n) begin
            tail = expected_chars.pop_back();
            tail.last_of_item = 1'b1;
            tail.pattern_done = last_char;
            expected_chars.push_back(tail);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [lcre_pkg::CHAR_W-1:0] random_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? lcre_pkg::CHAR_W'(lcre_pkg::CHAR_UP_A + r)
                        : lcre_pkg::CHAR_W'(lcre_pkg::CHAR_LO_A + (r - 26));
    endfunction

    function automatic logic [lcre_pkg::CHAR_W-1:0] random_digit();
        return lcre_pkg::CHAR_W'(lcre_pkg::CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [lcre_pkg::CHAR_W-1:0] random_other();
        logic [lcre_pkg::CHAR_W-1:0] c;
        do begin
            c = lcre_pkg::CHAR_W'($urandom_range(0, 255));
        end while (classify(c) != CLS_OTHER);
        return c;
    endfunction

    // Holds a request on the input until it is taken, then idles for a random gap.
    // With no gap the valid stays high so the next request follows back to back.
    task automatic send_request(logic [lcre_pkg::CHAR_W-1:0] c, logic last_char);
        int gap;
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_string_end <= last_char;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_expansion(c, last_char);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic release_sender();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_text(string s, bit end_last);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], end_last && (i == s.len() - 1));
        end
    endtask

    // Letters with short counts, some bare letters and other characters, sometimes led
    // by a stray digit; the last character always carries the end flag.
    task automatic send_random_pattern();
        logic [lcre_pkg::CHAR_W-1:0] text[$];
        int n_runs;
        int n_digits;
        int r;
        n_runs = $urandom_range(1, 5);
        if ($urandom_range(0, 19) == 0) begin
            text.push_back(random_digit());
        end
        repeat (n_runs) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                text.push_back(random_other());
            end else begin
                text.push_back(random_letter());
                r = $urandom_range(0, 99);
                n_digits = (r < 35) ? 0 : (r < 85) ? 1 : (r < 95) ? 2 : 3;
                if (n_digits == 2) begin
                    text.push_back(lcre_pkg::CHAR_W'(lcre_pkg::CHAR_ZERO +
                                                     $urandom_range(0, 6)));
                    text.push_back(random_digit());
                end else begin
                    repeat (n_digits) text.push_back(random_digit());
                end
            end
        end
        foreach (text[i]) begin
            send_request(text[i], i == text.size() - 1);
        end
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        stall_pct = 20;
        // Character below '0', stray digit, count of three, bare letter, saturation.
        send_text("/5A3z@Z999a0", 1'b0);
        send_request(8'hFF, 1'b0);
        send_text("[`{:", 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h80, 1'b0);
        send_text("m", 1'b1);
        // End on a stray digit and end on a zero count produce nothing.
        send_text("7", 1'b1);
        send_text("q0", 1'b1);
        send_text("x12#", 1'b1);
    endtask

    task automatic test_random_patterns(int n_requests);
        int stop_at;
        stop_at = requests_sent + n_requests;
        idle_on = 1'b1;
        stall_pct = 25;
        while (requests_sent < stop_at) send_random_pattern();
    endtask

    task automatic test_streaming(int n_requests);
        int stop_at;
        stop_at = requests_sent + n_requests;
        idle_on = 1'b0;
        stall_pct = 0;
        while (requests_sent < stop_at) send_random_pattern();
    endtask

    task automatic test_noise(int n_requests);
        logic [lcre_pkg::CHAR_W-1:0] c;
        idle_on = 1'b1;
        stall_pct = 40;
        repeat (n_requests) begin
            c = ($urandom_range(0, 9) < 3) ? random_digit()
                                           : lcre_pkg::CHAR_W'($urandom_range(0, 255));
            send_request(c, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_drain_between_patterns();
        idle_on = 1'b1;
        stall_pct = 60;
        repeat (4) begin
            send_random_pattern();
            release_sender();
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(8, 25);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        lcre_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $error("Result with no request pending: char_out %h", o_char_out);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (want.pattern_done) begin
                    patterns_closed++;
                end
                if (o_char_out !== want.char_out) begin
                    $error("char_out expected %h actual %h", want.char_out, o_char_out);
                    fail_count++;
                end
                if (o_last_of_item !== want.last_of_item) begin
                    $error("last_of_item expected %b actual %b",
                           want.last_of_item, o_last_of_item);
                    fail_count++;
                end
                if (o_pattern_done !== want.pattern_done) begin
                    $error("pattern_done expected %b actual %b",
                           want.pattern_done, o_pattern_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout with %0d results outstanding", expected_chars.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_patterns(110);
        test_streaming(30);
        test_noise(40);
        test_drain_between_patterns();
        release_sender();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d expanded characters.",
                 requests_sent, chars_checked);
        $display("Closed %0d patterns; longest run %0d, stalls and gaps on both sides.",
                 patterns_closed, longest_run);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
